>>> rtl/rsdf_pkg.sv
// Shared types, codes and constants for the RTP SSRC demux filter.
package rsdf_pkg;

  // Table geometry and fixed values
  localparam int unsigned RSDF_ENTRIES = 16;
  localparam int unsigned SSRC_W       = 32;
  localparam logic [7:0]  SDES_TYPE_RESET       = 8'd202;
  localparam logic [31:0] SSRC_GENERIC_FEEDBACK = 32'h0000_0001;

  // Stream port widths
  localparam int unsigned S_TDATA_W = 80;  // 74 payload bits, zero padded
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 8;   // 4 payload bits, zero padded

  // Command codes
  localparam logic [1:0] CMD_DEMUX  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // Table update request from the control path
  typedef struct packed {
    logic add_en;
    logic rm_en;
  } tbl_req_t;

  // Table lookup summary toward the control path
  typedef struct packed {
    logic hit;          // key matches a stream in use
    logic full;         // no free slot
    logic active;       // at least one stream in use now
    logic rest_active;  // a stream in use that does not hold the key
  } tbl_stat_t;

endpackage

>>> rtl/rsdf_table.sv
// Stream table: per-slot SSRC registers, parallel compare and update.
module rsdf_table #(
  parameter int unsigned ENTRIES = rsdf_pkg::RSDF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rsdf_pkg::SSRC_W-1:0] key_ssrc,
  input  logic [rsdf_pkg::SSRC_W-1:0] second_ssrc,
  input  logic                        second_valid,
  input  rsdf_pkg::tbl_req_t          req,
  output rsdf_pkg::tbl_stat_t         stat
);
  import rsdf_pkg::*;

  logic [ENTRIES-1:0] used;
  logic [ENTRIES-1:0] xused;
  logic [SSRC_W-1:0]  primary [ENTRIES];
  logic [SSRC_W-1:0]  extra   [ENTRIES];

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] add_sel;

  // Per-slot compare against the key
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = used[i] &&
                   ((primary[i] == key_ssrc) || (xused[i] && (extra[i] == key_ssrc)));
    end
  end

  // Lowest free slot as a one-hot vector
  assign free_vec = ~used;
  assign add_sel  = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});

  assign stat.hit         = |hit_vec;
  assign stat.full        = ~|free_vec;
  assign stat.active      = |used;
  assign stat.rest_active = |(used & ~hit_vec);

  // Slot flags: remove clears every hit slot, add claims the lowest free one
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      xused <= '0;
    end else if (req.rm_en) begin
      used  <= used & ~hit_vec;
      xused <= xused & ~hit_vec;
    end else if (req.add_en) begin
      used  <= used | add_sel;
      xused <= (xused & ~add_sel) | (add_sel & {ENTRIES{second_valid}});
    end
  end

  // SSRC payload, written only on add
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (req.add_en && add_sel[i]) begin
        primary[i] <= key_ssrc;
        extra[i]   <= second_valid ? second_ssrc : '0;
      end
    end
  end

endmodule

>>> rtl/rtp_ssrc_demux_filter.sv
// Top level of the RTP SSRC demux filter: input register, decision, result register.
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata, s_tuser: one command item
//  m_axis    out  m_tvalid/m_tready  m_tdata: accept, status, active
//  cfg       in   cfg_we             cfg_wdata: sdes_type_code
//
// One item per cycle sustained while m_tready stays high; each item is decided
// against the table in one pass while it sits in the input register.
// m_axis valid rises once the item moves from the input register into the
// result register.
// The table update and the result register load happen at the same edge,
// so the next item sees the updated table.
// Reset empties the table and sets sdes_type_code to 202; no clearing pass.
// A stall on m_tready holds the result and backs up through s_tready.
module rtp_ssrc_demux_filter #(
  parameter int unsigned ENTRIES = rsdf_pkg::RSDF_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  // lsb up: header_ok, rtcp_type[7:0], key_ssrc[31:0], second_ssrc[31:0],
  //         second_valid, zero pad
  input  logic [rsdf_pkg::S_TDATA_W-1:0] s_tdata,
  // lsb up: cmd[1:0], is_rtcp
  input  logic [rsdf_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // lsb up: accept, status[1:0], active, zero pad
  output logic [rsdf_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata
);
  import rsdf_pkg::*;

  logic [7:0] sdes_type_code;

  // Input register
  logic              in_valid;
  logic [1:0]        in_cmd;
  logic              in_is_rtcp;
  logic              in_header_ok;
  logic [7:0]        in_rtcp_type;
  logic [SSRC_W-1:0] in_key;
  logic [SSRC_W-1:0] in_second;
  logic              in_second_valid;

  // Result register
  logic       out_valid;
  logic       out_accept;
  logic [1:0] out_status;
  logic       out_active;

  logic       adv;
  tbl_req_t   req;
  tbl_stat_t  stat;
  logic       res_accept;
  logic [1:0] res_status;
  logic       res_active;

  // Item leaves the input register when the result slot is free or draining
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sdes_type_code <= SDES_TYPE_RESET;
    end else if (cfg_we) begin
      sdes_type_code <= cfg_wdata;
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd          <= s_tuser[1:0];
      in_is_rtcp      <= s_tuser[2];
      in_header_ok    <= s_tdata[0];
      in_rtcp_type    <= s_tdata[8:1];
      in_key          <= s_tdata[40:9];
      in_second       <= s_tdata[72:41];
      in_second_valid <= s_tdata[73];
    end
  end

  rsdf_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .key_ssrc     (in_key),
    .second_ssrc  (in_second),
    .second_valid (in_second_valid),
    .req          (req),
    .stat         (stat)
  );

  // Command decision
  always_comb begin
    res_accept = 1'b0;
    res_status = ST_MISS;
    res_active = stat.active;
    req        = '0;
    case (in_cmd)
      CMD_DEMUX: begin
        if (!in_is_rtcp) begin
          res_accept = stat.hit;
        end else if (!in_header_ok) begin
          res_accept = 1'b0;
        end else if (in_rtcp_type == sdes_type_code) begin
          res_accept = 1'b1;
        end else if (in_key == SSRC_GENERIC_FEEDBACK) begin
          res_accept = 1'b1;
        end else begin
          res_accept = stat.hit;
        end
        res_status = res_accept ? ST_OK : ST_MISS;
      end
      CMD_ADD: begin
        if (stat.hit) begin
          res_status = ST_DUP;
        end else if (stat.full) begin
          res_status = ST_FULL;
        end else begin
          res_accept = 1'b1;
          res_status = ST_OK;
          res_active = 1'b1;
          req.add_en = adv;
        end
      end
      CMD_REMOVE: begin
        res_accept = stat.hit;
        res_status = stat.hit ? ST_OK : ST_MISS;
        res_active = stat.rest_active;
        req.rm_en  = adv;
      end
      default: begin
        res_accept = 1'b0;
        res_status = ST_MISS;
      end
    endcase
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_accept <= res_accept;
      out_status <= res_status;
      out_active <= res_active;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W-4){1'b0}}, out_active, out_status, out_accept};

endmodule

>>> rtl/rsdf_checker.sv
// Port-level checks for the RTP SSRC demux filter, bound to the top level.
module rsdf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rsdf_pkg::M_TDATA_W-1:0] m_tdata
);
  import rsdf_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Accept is set exactly when the status is ok
  a_accept_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == ST_OK)))
    else $error("accept and status disagree");

  // Duplicate or full means the table holds a stream
  a_dup_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tdata[2:1] == ST_DUP) || (m_tdata[2:1] == ST_FULL)) |-> m_tdata[3])
    else $error("duplicate or full reported on an empty table");

  // With no result pending the input side is open
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rtp_ssrc_demux_filter rsdf_checker u_rsdf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/tb_rtp_ssrc_demux_filter.sv
// Self-checking testbench for the RTP SSRC demux filter: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_rtp_ssrc_demux_filter;
  import rsdf_pkg::*;

  localparam int unsigned N_SLOTS = RSDF_ENTRIES;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // spare command code, answered as a miss
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 156;

  // One command item as it travels on s_axis
  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_rtcp;
    logic        header_ok;
    logic [7:0]  rtcp_type;
    logic [31:0] key;
    logic [31:0] second;
    logic        second_valid;
  } filter_cmd_t;

  // One result as it travels on m_axis
  typedef struct packed {
    logic       accept;
    logic [1:0] status;
    logic       active;
  } filter_verdict_t;

  logic                 clk;
  logic                 rst;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic                 cfg_we;
  logic [7:0]           cfg_wdata;

  rtp_ssrc_demux_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Stream table as the block should hold it
  logic [N_SLOTS-1:0] slot_used;
  logic [N_SLOTS-1:0] slot_extra_used;
  logic [31:0]        slot_primary [N_SLOTS];
  logic [31:0]        slot_extra   [N_SLOTS];
  logic [7:0]         sdes_code;

  filter_cmd_t     cmd_backlog[$];       // items waiting for the driver
  filter_verdict_t pending_verdicts[$];  // results owed by the block
  logic [31:0]     seen_ssrc[$];         // recently added SSRCs, to make lookups hit

  int  mismatches;
  logic in_taken;
  int  hold_req, hold_served;

  always #5 clk = ~clk;

  // Append one item to the driver's backlog
  function automatic void queue_cmd(filter_cmd_t it);
    cmd_backlog = {cmd_backlog, it};
  endfunction

  // Does any stream in use hold this SSRC
  function automatic logic table_has(logic [31:0] ssrc);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_SLOTS; i++)
      if (slot_used[i] && (slot_primary[i] == ssrc || (slot_extra_used[i] && slot_extra[i] == ssrc)))
        hit = 1'b1;
    return hit;
  endfunction

  // Works out one result and applies the item to the table
  function automatic filter_verdict_t filter_decide(filter_cmd_t it);
    filter_verdict_t v;
    int slot;
    v.accept = 1'b0;
    v.status = ST_MISS;
    case (it.cmd)
      CMD_DEMUX: begin
        if (!it.is_rtcp) v.accept = table_has(it.key);
        else if (!it.header_ok) v.accept = 1'b0;
        else if (it.rtcp_type == sdes_code) v.accept = 1'b1;
        else if (it.key == SSRC_GENERIC_FEEDBACK) v.accept = 1'b1;
        else v.accept = table_has(it.key);
        v.status = v.accept ? ST_OK : ST_MISS;
      end
      CMD_ADD: begin
        slot = -1;
        for (int i = N_SLOTS - 1; i >= 0; i--)
          if (!slot_used[i]) slot = i;
        if (table_has(it.key)) begin
          v.status = ST_DUP;
        end else if (slot < 0) begin
          v.status = ST_FULL;
        end else begin
          slot_used[slot]       = 1'b1;
          slot_primary[slot]    = it.key;
          slot_extra[slot]      = it.second_valid ? it.second : 32'h0;
          slot_extra_used[slot] = it.second_valid;
          v.accept = 1'b1;
          v.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (slot_used[i] && (slot_primary[i] == it.key ||
                               (slot_extra_used[i] && slot_extra[i] == it.key))) begin
            slot_used[i]       = 1'b0;
            slot_extra_used[i] = 1'b0;
            v.accept = 1'b1;
          end
        end
        v.status = v.accept ? ST_OK : ST_MISS;
      end
      default: ;
    endcase
    v.active = |slot_used;
    return v;
  endfunction

  function automatic filter_cmd_t mk_cmd(logic [1:0] cmd, logic is_rtcp, logic header_ok,
                                         logic [7:0] rtcp_type, logic [31:0] key,
                                         logic [31:0] second, logic second_valid);
    filter_cmd_t it;
    it.cmd          = cmd;
    it.is_rtcp      = is_rtcp;
    it.header_ok    = header_ok;
    it.rtcp_type    = rtcp_type;
    it.key          = key;
    it.second       = second;
    it.second_valid = second_valid;
    return it;
  endfunction

  // SSRC draw: known streams, extremes, the feedback SSRC, or anything
  function automatic logic [31:0] pick_ssrc(int pool_pct);
    int r;
    r = $urandom_range(0, 99);
    if (seen_ssrc.size() > 0 && r < pool_pct)
      return seen_ssrc[$urandom_range(0, seen_ssrc.size() - 1)];
    if (r >= 95) return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
    if (r >= 90) return SSRC_GENERIC_FEEDBACK;
    return $urandom();
  endfunction

  function automatic filter_cmd_t rand_cmd(int add_pct, int rm_pct);
    filter_cmd_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) it.cmd = CMD_ADD;
    else if (r < add_pct + rm_pct) it.cmd = CMD_REMOVE;
    else if (r < 97) it.cmd = CMD_DEMUX;
    else it.cmd = CMD_UNUSED;
    it.is_rtcp      = 1'($urandom_range(0, 1));
    it.header_ok    = $urandom_range(0, 4) != 0;
    it.rtcp_type    = ($urandom_range(0, 2) == 0) ? sdes_code : 8'($urandom_range(0, 255));
    it.key          = pick_ssrc(it.cmd == CMD_ADD ? 25 : 65);
    it.second       = ($urandom_range(0, 4) == 0) ? pick_ssrc(100) : $urandom();
    it.second_valid = 1'($urandom_range(0, 1));
    if (it.cmd == CMD_ADD) begin
      seen_ssrc = {seen_ssrc, it.key};
      if (it.second_valid) seen_ssrc = {seen_ssrc, it.second};
      while (seen_ssrc.size() > 48) void'(seen_ssrc.pop_front());
    end
    return it;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(string what, filter_verdict_t want, filter_verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): expected accept=%0d status=%0d active=%0d, got accept=%0d status=%0d active=%0d",
               $realtime, what, want.accept, want.status, want.active,
               got.accept, got.status, got.active);
  endtask

  // Wait until every queued item went in and every result came back;
  // each look happens just after the falling edge, once the drivers settled
  task automatic drain_all();
    @(negedge clk);
    #1;
    while (cmd_backlog.size() != 0 || s_tvalid || pending_verdicts.size() != 0) begin
      @(negedge clk);
      #1;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_sdes(logic [7:0] code);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sdes_code = code;
  endtask

  // Sender: one item per transfer, random gaps between items
  always @(negedge clk) begin : drive_s
    static int tx_gap = 0;
    static int tx_mode_left = 0;
    static logic tx_calm = 1'b0;
    filter_cmd_t it;
    if (tx_mode_left == 0) begin
      tx_calm      = ($urandom_range(0, 2) == 0);
      tx_mode_left = $urandom_range(100, 300);
    end else begin
      tx_mode_left--;
    end
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // hold the offered item until it transfers
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_tvalid <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      it = cmd_backlog.pop_front();
      s_tdata  <= {6'd0, it.second_valid, it.second, it.key, it.rtcp_type, it.header_ok};
      s_tuser  <= {it.is_rtcp, it.cmd};
      s_tvalid <= 1'b1;
      tx_gap = pick_gap(tx_calm);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : drive_m
    static int rx_gap = 0;
    static int hold_left = 0;
    static int rx_mode_left = 0;
    static logic rx_calm = 1'b0;
    if (rx_mode_left == 0) begin
      rx_calm      = ($urandom_range(0, 2) == 0);
      rx_mode_left = $urandom_range(100, 300);
    end else begin
      rx_mode_left--;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left   = 80;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_gap = pick_gap(rx_calm);
    end
  end

  // Monitor: check results in order, predict each input transfer
  always @(posedge clk) begin : monitor
    filter_cmd_t it;
    filter_verdict_t got, want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[2:1], m_tdata[3]};
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("no result owed", '0, got);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.accept !== want.accept) flag_mismatch("accept", want, got);
          if (got.status !== want.status) flag_mismatch("status", want, got);
          if (got.active !== want.active) flag_mismatch("active", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        it.header_ok    = s_tdata[0];
        it.rtcp_type    = s_tdata[8:1];
        it.key          = s_tdata[40:9];
        it.second       = s_tdata[72:41];
        it.second_valid = s_tdata[73];
        it.cmd          = s_tuser[1:0];
        it.is_rtcp      = s_tuser[2];
        want = filter_decide(it);
        pending_verdicts = {pending_verdicts, want};
      end
    end
  end

  // Stimulus and end of run
  initial begin : stim
    logic [7:0] sdes_plan [RAND_PHASES];
    clk = 1'b0;
    rst = 1'b1;
    s_tdata = '0;
    s_tuser = '0;
    s_tvalid = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    hold_req = 0;
    hold_served = 0;
    slot_used = '0;
    slot_extra_used = '0;
    sdes_code = SDES_TYPE_RESET;
    sdes_plan = '{8'd0, 8'd255, 8'd202, 8'd0, 8'd1, 8'd254, 8'd255, 8'd200};
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, RTCP rules, duplicates, full table, remove by extra
    queue_cmd(mk_cmd(CMD_REMOVE, 0, 1, 8'd0,   32'd5,          32'd0, 0));
    queue_cmd(mk_cmd(CMD_DEMUX,  0, 1, 8'd202, 32'h0,          32'd0, 0));
    queue_cmd(mk_cmd(CMD_DEMUX,  1, 0, 8'd202, 32'h1,          32'd0, 0));
    queue_cmd(mk_cmd(CMD_DEMUX,  1, 1, 8'd202, 32'hFFFF_FFFF,  32'd0, 0));
    queue_cmd(mk_cmd(CMD_DEMUX,  1, 1, 8'd200, 32'h1,          32'd0, 0));
    queue_cmd(mk_cmd(CMD_DEMUX,  1, 1, 8'd200, 32'h1234_5678,  32'd0, 0));
    queue_cmd(mk_cmd(CMD_UNUSED, 1, 1, 8'd202, 32'h1,          32'd0, 1));
    queue_cmd(mk_cmd(CMD_ADD,    0, 1, 8'd0,   32'h0,  32'hFFFF_FFFF, 1));
    queue_cmd(mk_cmd(CMD_ADD,    0, 1, 8'd0,   32'h0,          32'd7, 0));
    queue_cmd(mk_cmd(CMD_ADD,    0, 1, 8'd0,   32'hFFFF_FFFF,  32'd8, 1));
    queue_cmd(mk_cmd(CMD_DEMUX,  0, 0, 8'd0,   32'hFFFF_FFFF,  32'd0, 0));
    queue_cmd(mk_cmd(CMD_DEMUX,  1, 1, 8'd255, 32'h0,          32'd0, 0));
    queue_cmd(mk_cmd(CMD_ADD,    0, 1, 8'd0,   32'h0BAD, 32'hFFFF_0000, 0));
    for (int i = 0; i < N_SLOTS - 2; i++)
      queue_cmd(mk_cmd(CMD_ADD, 0, 1, 8'd0, 32'h100 + i, 32'd0, 0));
    queue_cmd(mk_cmd(CMD_ADD,    0, 1, 8'd0,   32'hABCD,       32'd0, 0));
    queue_cmd(mk_cmd(CMD_ADD,    0, 1, 8'd0,   32'h0,          32'd0, 0));
    queue_cmd(mk_cmd(CMD_REMOVE, 0, 1, 8'd0,   32'hFFFF_FFFF,  32'd0, 0));
    drain_all();

    // Random phases, each under its own SDES type; even phases fill, odd ones empty
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_sdes(p == 3 ? 8'($urandom_range(0, 255)) : sdes_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_cmd(rand_cmd(p % 2 == 0 ? 35 : 15, p % 2 == 0 ? 10 : 35));
        if (p == 5 && n == PHASE_ITEMS / 2) drain_all();
      end
      if (p == 2) hold_req++;
      drain_all();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("** rtp_ssrc_demux_filter: PASSED **");
    else
      $display("** rtp_ssrc_demux_filter: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** rtp_ssrc_demux_filter: FAILED **");
    $finish;
  end

endmodule
